### sv/wsfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfe_pkg
// Shared types and constants for the client frame encoder.
// ----------------------------------------------------------------------------
package wsfe_pkg;

	localparam int LENGTH_BITS_DEF = 32;
	localparam int CFG_W           = 32;
	localparam int IDX_W           = 4;

	localparam logic       CMD_START = 1'b0;
	localparam logic       CMD_DATA  = 1'b1;

	localparam logic [7:0] FIN_BIT     = 8'h80;
	localparam logic [7:0] MASK_BIT    = 8'h80;
	localparam logic [6:0] LEN16_CODE  = 7'd126;
	localparam logic [6:0] LEN64_CODE  = 7'd127;
	localparam logic [31:0] LEN16_MIN  = 32'd126;
	localparam logic [31:0] LEN64_MIN  = 32'd65536;
	localparam logic [CFG_W-1:0] CAP_RESET = 32'd4096;

	localparam logic [IDX_W-1:0] HDR_CNT_SHORT = 4'd6;
	localparam logic [IDX_W-1:0] HDR_CNT_MID   = 4'd8;
	localparam logic [IDX_W-1:0] HDR_CNT_LONG  = 4'd14;

	localparam logic [1:0] FORM_SHORT = 2'd0;
	localparam logic [1:0] FORM_MID   = 2'd1;
	localparam logic [1:0] FORM_LONG  = 2'd2;

	typedef struct packed {
		logic [7:0] byte_val;
		logic       last;
		logic       rej;
		logic       is_final;
	} hdr_t;

endpackage

### sv/websocket_frame_encoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_encoder_top
// Client-side masked frame encoder: header generation, payload masking and
// capacity rejection.
// ----------------------------------------------------------------------------
// A payload item gives at most one byte, so payload streams at one byte per
// cycle while out_ready is high. A start item stays in the input register
// until the header byte counter passes its last header byte (6, 8 or 14 by
// length form; 1 on a rejection). Items pass an input register and an output
// register; out_ready reaches in_ready through the input stage.
module websocket_frame_encoder_top #(
	parameter int LENGTH_BITS = wsfe_pkg::LENGTH_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [wsfe_pkg::CFG_W-1:0]  cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        cmd,
	input  logic [3:0]                  opcode,
	input  logic [31:0]                 frame_length,
	input  logic [31:0]                 mask_key,
	input  logic [7:0]                  data_byte,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [7:0]                  out_byte,
	output logic                        last,
	output logic                        rejected
);

	localparam int LEN_W = (LENGTH_BITS < 32) ? LENGTH_BITS : 32;

	logic [wsfe_pkg::CFG_W-1:0] cap_q;

	logic                       valid_s1;
	logic                       cmd_s1;
	logic [3:0]                 op_s1;
	logic [LEN_W-1:0]           len_s1;
	logic [31:0]                key_s1;
	logic [7:0]                 data_s1;

	logic [wsfe_pkg::IDX_W-1:0] hdr_idx_q;

	logic [31:0]                key_q;
	logic [1:0]                 key_idx_q;
	logic [LEN_W-1:0]           left_q;
	logic                       open_q;
	logic                       disc_q;

	logic                       out_valid_q;
	logic [7:0]                 out_byte_q;
	logic                       last_q;
	logic                       rej_q;

	wsfe_pkg::hdr_t             hdr;

	logic                       in_accept;
	logic                       pay_emit;
	logic                       pay_last;
	logic [7:0]                 pay_byte;
	logic                       res_valid;
	logic                       res_final;
	logic                       out_load;
	logic                       emit;
	logic                       s1_done;
	logic [LEN_W-1:0]           disc_left;

	wsfe_hdr #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_hdr (
		.op  (op_s1),
		.len (len_s1),
		.key (key_s1),
		.cap (cap_q),
		.idx (hdr_idx_q),
		.hdr (hdr)
	);

	assign pay_emit  = !disc_q && open_q && (left_q != '0);
	assign pay_last  = (left_q == LEN_W'(1));
	assign pay_byte  = data_s1 ^ 8'(key_q >> {2'd3 - key_idx_q, 3'b000});
	assign res_valid = valid_s1 && ((cmd_s1 == wsfe_pkg::CMD_START) || pay_emit);
	assign res_final = (cmd_s1 == wsfe_pkg::CMD_START) ? hdr.is_final : 1'b1;
	assign out_load  = !out_valid_q || out_ready;
	assign emit      = res_valid && out_load;
	assign s1_done   = valid_s1 && (!res_valid || (out_load && res_final));
	assign in_ready  = !valid_s1 || s1_done;
	assign in_accept = in_valid && in_ready;
	assign disc_left = left_q - ((left_q != '0) ? LEN_W'(1) : LEN_W'(0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= wsfe_pkg::CAP_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_done) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_s1  <= cmd;
			op_s1   <= opcode;
			len_s1  <= frame_length[LEN_W-1:0];
			key_s1  <= mask_key;
			data_s1 <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_idx_q <= '0;
		end else if (s1_done) begin
			hdr_idx_q <= '0;
		end else if (emit && (cmd_s1 == wsfe_pkg::CMD_START)) begin
			hdr_idx_q <= hdr_idx_q + wsfe_pkg::IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q     <= '0;
			key_idx_q <= '0;
			left_q    <= '0;
			open_q    <= 1'b0;
			disc_q    <= 1'b0;
		end else if (s1_done) begin
			if (cmd_s1 == wsfe_pkg::CMD_START) begin
				key_q     <= key_s1;
				key_idx_q <= '0;
				left_q    <= len_s1;
				open_q    <= !hdr.rej && (len_s1 != '0);
				disc_q    <= hdr.rej && (len_s1 != '0);
			end else if (disc_q) begin
				left_q <= disc_left;
				disc_q <= (disc_left != '0);
			end else if (!pay_emit) begin
				open_q <= 1'b0;
			end else begin
				left_q    <= left_q - LEN_W'(1);
				key_idx_q <= key_idx_q + 2'd1;
				open_q    <= !pay_last;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (cmd_s1 == wsfe_pkg::CMD_START) begin
				out_byte_q <= hdr.byte_val;
				last_q     <= hdr.last;
				rej_q      <= hdr.rej;
			end else begin
				out_byte_q <= pay_byte;
				last_q     <= pay_last;
				rej_q      <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;
	assign rejected  = rej_q;

	// checks
	a_rej_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && rej_q |-> last_q && (out_byte_q == 8'h00))
		else $error("rejection item malformed");

	a_mode_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(open_q && disc_q))
		else $error("open and discarding at once");

	a_disc_left: assert property (@(posedge clk) disable iff (!arst_n)
		disc_q |-> (left_q != '0))
		else $error("discarding with nothing left");

	a_hdr_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(hdr_idx_q != '0) |-> valid_s1 && (cmd_s1 == wsfe_pkg::CMD_START) && !hdr.rej)
		else $error("header counter running without a start item");

endmodule

### sv/wsfe_hdr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfe_hdr
// Header byte select: length form, capacity check and the byte at a given
// header position.
// ----------------------------------------------------------------------------
module wsfe_hdr #(
	parameter int LENGTH_BITS = wsfe_pkg::LENGTH_BITS_DEF
) (
	input  logic [3:0]                            op,
	input  logic [((LENGTH_BITS < 32) ? LENGTH_BITS : 32)-1:0] len,
	input  logic [31:0]                           key,
	input  logic [wsfe_pkg::CFG_W-1:0]            cap,
	input  logic [wsfe_pkg::IDX_W-1:0]            idx,
	output wsfe_pkg::hdr_t                        hdr
);

	logic [31:0]                  len_ext;
	logic [63:0]                  len64;
	logic [1:0]                   form;
	logic [wsfe_pkg::IDX_W-1:0]   cnt;
	logic [wsfe_pkg::IDX_W-1:0]   key_base;
	logic [wsfe_pkg::IDX_W-1:0]   rel;
	logic [1:0]                   kr;
	logic [32:0]                  total;
	logic                         rej;
	logic [7:0]                   b;

	assign len_ext = 32'(len);
	assign len64   = 64'(len);

	always_comb begin
		if (len_ext >= wsfe_pkg::LEN64_MIN) begin
			form = wsfe_pkg::FORM_LONG;
			cnt  = wsfe_pkg::HDR_CNT_LONG;
		end else if (len_ext >= wsfe_pkg::LEN16_MIN) begin
			form = wsfe_pkg::FORM_MID;
			cnt  = wsfe_pkg::HDR_CNT_MID;
		end else begin
			form = wsfe_pkg::FORM_SHORT;
			cnt  = wsfe_pkg::HDR_CNT_SHORT;
		end
	end

	assign total    = 33'(len_ext) + 33'(cnt);
	assign rej      = total > 33'(cap);
	assign key_base = cnt - wsfe_pkg::IDX_W'(4);
	assign rel      = key_base - wsfe_pkg::IDX_W'(1) - idx;
	assign kr       = 2'd3 - 2'(idx - key_base);

	always_comb begin
		b = 8'h00;
		if (idx == '0) begin
			b = wsfe_pkg::FIN_BIT | {4'h0, op};
		end else if (idx >= key_base) begin
			b = 8'(key >> {kr, 3'b000});
		end else if (idx == wsfe_pkg::IDX_W'(1)) begin
			case (form)
				wsfe_pkg::FORM_SHORT: b = wsfe_pkg::MASK_BIT | {1'b0, len_ext[6:0]};
				wsfe_pkg::FORM_MID:   b = wsfe_pkg::MASK_BIT | {1'b0, wsfe_pkg::LEN16_CODE};
				wsfe_pkg::FORM_LONG:  b = wsfe_pkg::MASK_BIT | {1'b0, wsfe_pkg::LEN64_CODE};
				default:              b = 8'h00;
			endcase
		end else begin
			b = 8'(len64 >> {rel[2:0], 3'b000});
		end
	end

	always_comb begin
		hdr.rej      = rej;
		hdr.byte_val = rej ? 8'h00 : b;
		hdr.is_final = rej || (idx == cnt - wsfe_pkg::IDX_W'(1));
		hdr.last     = rej || ((len_ext == 32'd0) && (idx == cnt - wsfe_pkg::IDX_W'(1)));
	end

endmodule
